// File: rtl/jsu_pkg.sv
// ----------------------------------------------------------------------------
// jsu_pkg
// Shared types and constants of the JSON string unescaper: the queue entry
// that carries one decoded step from front to back, error codes, sizes.
// ----------------------------------------------------------------------------
`default_nettype none

package jsu_pkg;

  // Default depth of the queue between front and back (at least 2).
  localparam int unsigned FIFO_DEPTH_DEF = 4;

  // Error codes as they appear on the result word.
  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_NO_QUOTE    = 4'd1;
  localparam logic [3:0] ERR_CONTROL     = 4'd2;
  localparam logic [3:0] ERR_DANGLING    = 4'd3;
  localparam logic [3:0] ERR_BAD_ESC     = 4'd4;
  localparam logic [3:0] ERR_SHORT_UNI   = 4'd5;
  localparam logic [3:0] ERR_BAD_HEX     = 4'd6;
  localparam logic [3:0] ERR_NO_LOW      = 4'd7;
  localparam logic [3:0] ERR_BAD_LOW_HEX = 4'd8;
  localparam logic [3:0] ERR_LOW_RANGE   = 4'd9;
  localparam logic [3:0] ERR_UNTERM      = 4'd10;

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_STR,
    PH_ESC,
    PH_HEX,
    PH_LOWBS,
    PH_LOWU,
    PH_LOWHEX
  } phase_e;

  // One queue entry: one to four result words of a single input word.
  typedef struct packed {
    logic [1:0]      last_idx;  // number of result words minus one
    logic [3:0][7:0] bytes;     // content bytes, index 0 first
    logic            content;   // words carry content bytes
    logic            done;      // closing quote
    logic [3:0]      err;       // error code, ERR_NONE otherwise
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

endpackage

`default_nettype wire

// File: rtl/jsu_front.sv
// ----------------------------------------------------------------------------
// jsu_front
// Accepts raw bytes, tracks the string/escape/hex phase and turns each byte
// into at most one queue entry (UTF-8 bytes, done marker or error).
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_front (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    s_tvalid_i,
  output logic                   s_tready_o,
  input  wire  [7:0]             in_byte_i,
  input  wire                    start_req_i,
  input  wire                    end_of_input_i,
  input  jsu_pkg::fifo_status_t  status_i,
  output logic                   push_o,
  output jsu_pkg::entry_t        entry_o
);

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  function automatic jsu_pkg::entry_t mk_err(input logic [3:0] code);
    jsu_pkg::entry_t e;
    e     = '0;
    e.err = code;
    return e;
  endfunction

  function automatic jsu_pkg::entry_t mk_byte(input logic [7:0] b);
    jsu_pkg::entry_t e;
    e          = '0;
    e.content  = 1'b1;
    e.bytes[0] = b;
    return e;
  endfunction

  function automatic jsu_pkg::entry_t mk_utf8(input logic [20:0] cp);
    jsu_pkg::entry_t e;
    e         = '0;
    e.content = 1'b1;
    if (cp <= 21'h7F) begin
      e.bytes[0] = cp[7:0];
    end else if (cp <= 21'h7FF) begin
      e.last_idx = 2'd1;
      e.bytes[0] = {3'b110, cp[10:6]};
      e.bytes[1] = {2'b10, cp[5:0]};
    end else if (cp <= 21'hFFFF) begin
      e.last_idx = 2'd2;
      e.bytes[0] = {4'b1110, cp[15:12]};
      e.bytes[1] = {2'b10, cp[11:6]};
      e.bytes[2] = {2'b10, cp[5:0]};
    end else begin
      e.last_idx = 2'd3;
      e.bytes[0] = {5'b11110, cp[20:18]};
      e.bytes[1] = {2'b10, cp[17:12]};
      e.bytes[2] = {2'b10, cp[11:6]};
      e.bytes[3] = {2'b10, cp[5:0]};
    end
    return e;
  endfunction

  jsu_pkg::phase_e phase_q, phase_d;
  logic [15:0]     acc_q, acc_d;
  logic [9:0]      hs_q, hs_d;     // low ten bits of the pending high surrogate
  logic [1:0]      dc_q, dc_d;

  logic            accept;
  logic            hex_ok;
  logic [3:0]      hex_v;
  logic [15:0]     acc_new;
  logic [4:0]      plane;
  logic            push_d;
  jsu_pkg::entry_t ent_d;

  assign s_tready_o = !status_i.full;
  assign accept     = s_tvalid_i && s_tready_o;

  always_comb begin
    hex_ok = 1'b1;
    hex_v  = 4'd0;
    if (in_byte_i >= 8'h30 && in_byte_i <= 8'h39) begin
      hex_v = 4'(in_byte_i - 8'h30);
    end else if (in_byte_i >= 8'h61 && in_byte_i <= 8'h66) begin
      hex_v = 4'(in_byte_i - 8'h57);
    end else if (in_byte_i >= 8'h41 && in_byte_i <= 8'h46) begin
      hex_v = 4'(in_byte_i - 8'h37);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign acc_new = {acc_q[11:0], hex_v};
  // Supplementary plane: high surrogate bits 9..6 plus one.
  assign plane   = {1'b0, hs_q[9:6]} + 5'd1;

  always_comb begin
    phase_d = phase_q;
    acc_d   = acc_q;
    hs_d    = hs_q;
    dc_d    = dc_q;
    push_d  = 1'b0;
    ent_d   = '0;
    if (start_req_i) begin
      acc_d = '0;
      hs_d  = '0;
      dc_d  = '0;
      if (end_of_input_i || in_byte_i != CH_QUOTE) begin
        push_d  = 1'b1;
        ent_d   = mk_err(jsu_pkg::ERR_NO_QUOTE);
        phase_d = jsu_pkg::PH_IDLE;
      end else begin
        phase_d = jsu_pkg::PH_STR;
      end
    end else if (end_of_input_i) begin
      phase_d = jsu_pkg::PH_IDLE;
      push_d  = 1'b1;
      case (phase_q)
        jsu_pkg::PH_STR:    ent_d = mk_err(jsu_pkg::ERR_UNTERM);
        jsu_pkg::PH_ESC:    ent_d = mk_err(jsu_pkg::ERR_DANGLING);
        jsu_pkg::PH_HEX:    ent_d = mk_err(jsu_pkg::ERR_SHORT_UNI);
        jsu_pkg::PH_LOWBS,
        jsu_pkg::PH_LOWU,
        jsu_pkg::PH_LOWHEX: ent_d = mk_err(jsu_pkg::ERR_NO_LOW);
        default:            push_d = 1'b0;
      endcase
    end else begin
      case (phase_q)
        jsu_pkg::PH_STR: begin
          if (in_byte_i == CH_QUOTE) begin
            phase_d    = jsu_pkg::PH_IDLE;
            push_d     = 1'b1;
            ent_d      = '0;
            ent_d.done = 1'b1;
          end else if (in_byte_i < CH_SPACE) begin
            phase_d = jsu_pkg::PH_IDLE;
            push_d  = 1'b1;
            ent_d   = mk_err(jsu_pkg::ERR_CONTROL);
          end else if (in_byte_i == CH_BSLASH) begin
            phase_d = jsu_pkg::PH_ESC;
          end else begin
            push_d = 1'b1;
            ent_d  = mk_byte(in_byte_i);
          end
        end
        jsu_pkg::PH_ESC: begin
          phase_d = jsu_pkg::PH_STR;
          push_d  = 1'b1;
          case (in_byte_i)
            CH_QUOTE, CH_BSLASH, CH_SLASH: ent_d = mk_byte(in_byte_i);
            CH_B: ent_d = mk_byte(8'h08);
            CH_F: ent_d = mk_byte(8'h0C);
            CH_N: ent_d = mk_byte(8'h0A);
            CH_R: ent_d = mk_byte(8'h0D);
            CH_T: ent_d = mk_byte(8'h09);
            CH_U: begin
              push_d  = 1'b0;
              phase_d = jsu_pkg::PH_HEX;
              acc_d   = '0;
              dc_d    = '0;
            end
            default: begin
              phase_d = jsu_pkg::PH_IDLE;
              ent_d   = mk_err(jsu_pkg::ERR_BAD_ESC);
            end
          endcase
        end
        jsu_pkg::PH_HEX, jsu_pkg::PH_LOWHEX: begin
          if (!hex_ok) begin
            phase_d = jsu_pkg::PH_IDLE;
            push_d  = 1'b1;
            ent_d   = mk_err((phase_q == jsu_pkg::PH_HEX) ? jsu_pkg::ERR_BAD_HEX
                                                          : jsu_pkg::ERR_BAD_LOW_HEX);
          end else begin
            acc_d = acc_new;
            if (dc_q != 2'd3) begin
              dc_d = dc_q + 2'd1;
            end else begin
              dc_d = 2'd0;
              if (phase_q == jsu_pkg::PH_HEX) begin
                if (acc_new[15:10] == 6'b110110) begin
                  hs_d    = acc_new[9:0];
                  phase_d = jsu_pkg::PH_LOWBS;
                end else begin
                  phase_d = jsu_pkg::PH_STR;
                  push_d  = 1'b1;
                  ent_d   = mk_utf8({5'd0, acc_new});
                end
              end else if (acc_new[15:10] != 6'b110111) begin
                phase_d = jsu_pkg::PH_IDLE;
                push_d  = 1'b1;
                ent_d   = mk_err(jsu_pkg::ERR_LOW_RANGE);
              end else begin
                phase_d = jsu_pkg::PH_STR;
                push_d  = 1'b1;
                ent_d   = mk_utf8({plane, hs_q[5:0], acc_new[9:0]});
              end
            end
          end
        end
        jsu_pkg::PH_LOWBS: begin
          if (in_byte_i != CH_BSLASH) begin
            phase_d = jsu_pkg::PH_IDLE;
            push_d  = 1'b1;
            ent_d   = mk_err(jsu_pkg::ERR_NO_LOW);
          end else begin
            phase_d = jsu_pkg::PH_LOWU;
          end
        end
        jsu_pkg::PH_LOWU: begin
          if (in_byte_i != CH_U) begin
            phase_d = jsu_pkg::PH_IDLE;
            push_d  = 1'b1;
            ent_d   = mk_err(jsu_pkg::ERR_NO_LOW);
          end else begin
            phase_d = jsu_pkg::PH_LOWHEX;
            acc_d   = '0;
            dc_d    = '0;
          end
        end
        default: phase_d = jsu_pkg::PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= jsu_pkg::PH_IDLE;
      acc_q   <= '0;
      hs_q    <= '0;
      dc_q    <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      acc_q   <= acc_d;
      hs_q    <= hs_d;
      dc_q    <= dc_d;
    end
  end

  assign push_o  = accept && push_d;
  assign entry_o = ent_d;

endmodule

`default_nettype wire

// File: rtl/jsu_fifo.sv
// ----------------------------------------------------------------------------
// jsu_fifo
// Short queue of decoded entries between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_fifo #(
  parameter int unsigned DEPTH = jsu_pkg::FIFO_DEPTH_DEF
) (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  wire                    push_i,
  input  jsu_pkg::entry_t        entry_i,
  input  wire                    pop_i,
  output jsu_pkg::entry_t        head_o,
  output jsu_pkg::fifo_status_t  status_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  jsu_pkg::entry_t mem_q [DEPTH];
  logic [IdxW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  function automatic logic [IdxW-1:0] nxt(input logic [IdxW-1:0] p);
    return (p == IdxW'(DEPTH - 1)) ? '0 : p + IdxW'(1);
  endfunction

  assign status_o.full  = (cnt_q == CntW'(DEPTH));
  assign status_o.empty = (cnt_q == '0);
  assign head_o         = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= nxt(wr_q);
      end
      if (pop_i) begin
        rd_q <= nxt(rd_q);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.full |-> !push_i) else $error("push into full queue");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_o.empty |-> !pop_i) else $error("pop from empty queue");

  a_ptr_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0 || status_o.full) |-> (wr_q == rd_q))
    else $error("queue pointers disagree with fill count");

endmodule

`default_nettype wire

// File: rtl/jsu_back.sv
// ----------------------------------------------------------------------------
// jsu_back
// Unrolls the head entry into result words in an output register, one per
// cycle unless the output stalls; pops the entry with its last word.
// ----------------------------------------------------------------------------
`default_nettype none

module jsu_back (
  input  wire                    clk_i,
  input  wire                    rst_ni,
  input  jsu_pkg::entry_t        head_i,
  input  jsu_pkg::fifo_status_t  status_i,
  output logic                   pop_o,
  output logic                   m_tvalid_o,
  input  wire                    m_tready_i,
  output logic [7:0]             out_byte_o,
  output logic                   byte_valid_o,
  output logic                   string_done_o,
  output logic [3:0]             error_code_o,
  output logic                   run_last_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       bv_q, done_q, last_q;
  logic [3:0] err_q;
  logic [1:0] idx_q;
  logic       load, is_last;

  assign load    = !status_i.empty && (!valid_q || m_tready_i);
  assign is_last = (idx_q == head_i.last_idx);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= 1'b1;
        idx_q   <= is_last ? 2'd0 : idx_q + 2'd1;
      end else if (m_tready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      bv_q   <= head_i.content;
      done_q <= head_i.done;
      err_q  <= head_i.err;
      last_q <= is_last;
    end
  end

  assign m_tvalid_o    = valid_q;
  assign out_byte_o    = byte_q;
  assign byte_valid_o  = bv_q;
  assign string_done_o = done_q;
  assign error_code_o  = err_q;
  assign run_last_o    = last_q;

  a_idx_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !status_i.empty |-> (idx_q <= head_i.last_idx))
    else $error("word index past end of entry");

  a_idx_rest : assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.empty |-> (idx_q == 2'd0)) else $error("word index left over");

endmodule

`default_nettype wire

// File: rtl/json_string_unescape_utf8_top.sv
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string unescaper: raw string bytes in, UTF-8 content bytes, done
// marker and error reports out.
// ----------------------------------------------------------------------------
//  channel   dir  tdata                    tuser                   tlast
//  s_axis    in   [7:0] in_byte            [0] start_req           end_of_input
//  m_axis    out  [7:0] out_byte,          [0] byte_valid,         run_last
//                 [11:8] error_code        [1] string_done
//
//  Flow: one input word per cycle while the queue is not full; the front
//  decodes it in the cycle it is accepted and queues up to one entry. The
//  back sends one result word per cycle unless m_axis stalls; the queue
//  (FIFO_DEPTH entries) absorbs the words of a multi-byte \u escape.
//  Path: an accepted word's entry is written into the queue, then loaded
//  into the output register when it is at the head and the register is free.
//  Reset: asynchronous, active low; clears phase, queue and output valid.
//  Stalls: s_axis_tready_o falls only when the queue is full; m_axis
//  back-pressure reaches the input only through the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module json_string_unescape_utf8_top #(
  parameter int unsigned FIFO_DEPTH = jsu_pkg::FIFO_DEPTH_DEF
) (
  input  wire         clk_i,
  input  wire         rst_ni,
  // input words
  input  wire         s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  wire  [7:0]  s_axis_tdata_i,   // [7:0] in_byte
  input  wire         s_axis_tuser_i,   // [0] start_req
  input  wire         s_axis_tlast_i,   // end_of_input
  // result words
  output logic        m_axis_tvalid_o,
  input  wire         m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [7:0] out_byte, [11:8] error_code, rest 0
  output logic [1:0]  m_axis_tuser_o,   // [0] byte_valid, [1] string_done
  output logic        m_axis_tlast_o    // run_last
);

  jsu_pkg::entry_t       push_entry, head;
  jsu_pkg::fifo_status_t status;
  logic                  push, pop;
  logic [7:0]            out_byte;
  logic [3:0]            error_code;
  logic                  byte_valid, string_done;

  // Front: phase tracking and decoding, one entry per input word at most.
  jsu_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_tvalid_i     (s_axis_tvalid_i),
    .s_tready_o     (s_axis_tready_o),
    .in_byte_i      (s_axis_tdata_i),
    .start_req_i    (s_axis_tuser_i),
    .end_of_input_i (s_axis_tlast_i),
    .status_i       (status),
    .push_o         (push),
    .entry_o        (push_entry)
  );

  // Queue decouples decode from the multi-word drain.
  jsu_fifo #(
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (push_entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  // Back: one result word per cycle into the output register unless m_axis stalls.
  jsu_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .status_i      (status),
    .pop_o         (pop),
    .m_tvalid_o    (m_axis_tvalid_o),
    .m_tready_i    (m_axis_tready_i),
    .out_byte_o    (out_byte),
    .byte_valid_o  (byte_valid),
    .string_done_o (string_done),
    .error_code_o  (error_code),
    .run_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, error_code, out_byte};
  assign m_axis_tuser_o = {string_done, byte_valid};

endmodule

`default_nettype wire
